### design/psu_pkg.sv
// Package for the PNG scanline unfilter: sizes, filter codes, register indexes
// and the word type that travels from the front end through the queue to the back end.
// No dependencies; every other design file except psu_ram refers to it by scoped names.
package psu_pkg;

    localparam int MAX_ROW_BYTES = 32768;
    localparam int MAX_CHANNELS  = 8;
    localparam int ROW_LIMIT     = 4096;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CH_W     = $clog2(MAX_CHANNELS);
    localparam int PIX_W    = $clog2(ROW_LIMIT);
    localparam int IDX_W    = $clog2(MAX_ROW_BYTES);
    localparam int CNT_CH_W = 4;
    localparam int ROW_W    = 13;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    localparam logic [2:0] FT_NONE     = 3'd0;
    localparam logic [2:0] FT_SUB      = 3'd1;
    localparam logic [2:0] FT_UP       = 3'd2;
    localparam logic [2:0] FT_AVG      = 3'd3;
    localparam logic [2:0] FT_PAETH    = 3'd4;
    localparam logic [2:0] FT_AVG_ZERO = 3'd5;
    localparam logic [2:0] FT_SUB_ALT  = 3'd6;

    localparam logic [1:0] REG_ROW_PIXELS  = 2'd0;
    localparam logic [1:0] REG_SRC_CHANNEL = 2'd1;
    localparam logic [1:0] REG_DST_CHANNEL = 2'd2;

    typedef enum logic [2:0] {
        PRED_NONE,
        PRED_SUB,
        PRED_UP,
        PRED_AVG,
        PRED_PAETH,
        PRED_AVG0
    } pred_t;

    typedef struct packed {
        pred_t              pred;
        logic [7:0]         data;
        logic [IDX_W-1:0]   idx;
        logic               first_px;
        logic [CH_W-1:0]    fill_cnt;
        logic               row_last;
    } item_t;

endpackage

### design/psu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/psu_front.sv
// Front end of the unfilter: tracks the pixel and channel position, classifies the
// filter type and builds one queue word per accepted byte. Depends on psu_pkg.
module psu_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [2:0]                      filter_type,
    input  logic [7:0]                      data_byte,
    input  logic                            new_image,
    input  logic [psu_pkg::ROW_W-1:0]       row_pixels,
    input  logic [psu_pkg::CNT_CH_W-1:0]    src_channels,
    input  logic [psu_pkg::CNT_CH_W-1:0]    dst_channels,
    output psu_pkg::item_t                  item
);

    logic [psu_pkg::PIX_W-1:0]    pix_reg, pix_next;
    logic [psu_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [psu_pkg::CNT_CH_W-1:0] sc, dc_raw, dc;
    logic [psu_pkg::ROW_W-1:0]    rows;
    logic [psu_pkg::PIX_W-1:0]    p;
    logic [psu_pkg::CH_W-1:0]     c;
    logic                         last_ch, last_px;
    psu_pkg::pred_t               pred;

    always_comb
    begin
        if (src_channels == '0)
            sc = psu_pkg::CNT_CH_W'(1);
        else if (src_channels > psu_pkg::CNT_CH_W'(psu_pkg::MAX_CHANNELS))
            sc = psu_pkg::CNT_CH_W'(psu_pkg::MAX_CHANNELS);
        else
            sc = src_channels;

        if (dst_channels == '0)
            dc_raw = psu_pkg::CNT_CH_W'(1);
        else if (dst_channels > psu_pkg::CNT_CH_W'(psu_pkg::MAX_CHANNELS))
            dc_raw = psu_pkg::CNT_CH_W'(psu_pkg::MAX_CHANNELS);
        else
            dc_raw = dst_channels;
        dc = (dc_raw < sc) ? sc : dc_raw;

        if (row_pixels == '0)
            rows = psu_pkg::ROW_W'(1);
        else if (row_pixels > psu_pkg::ROW_W'(psu_pkg::ROW_LIMIT))
            rows = psu_pkg::ROW_W'(psu_pkg::ROW_LIMIT);
        else
            rows = row_pixels;
    end

    always_comb
    begin
        p       = new_image ? '0 : pix_reg;
        c       = new_image ? '0 : ch_reg;
        last_ch = ({1'b0, c} + psu_pkg::CNT_CH_W'(1)) >= sc;
        last_px = ({1'b0, p} + psu_pkg::ROW_W'(1)) >= rows;

        unique case (filter_type)
            psu_pkg::FT_NONE:     pred = psu_pkg::PRED_NONE;
            psu_pkg::FT_SUB:      pred = psu_pkg::PRED_SUB;
            psu_pkg::FT_SUB_ALT:  pred = psu_pkg::PRED_SUB;
            psu_pkg::FT_UP:       pred = psu_pkg::PRED_UP;
            psu_pkg::FT_AVG:      pred = psu_pkg::PRED_AVG;
            psu_pkg::FT_PAETH:    pred = psu_pkg::PRED_PAETH;
            psu_pkg::FT_AVG_ZERO: pred = psu_pkg::PRED_AVG0;
            default:              pred = psu_pkg::PRED_NONE;
        endcase

        item.pred     = pred;
        item.data     = data_byte;
        item.idx      = {p, c};
        item.first_px = (p == '0);
        item.fill_cnt = last_ch ? psu_pkg::CH_W'(dc - sc) : '0;
        item.row_last = last_ch && last_px;
    end

    always_comb
    begin
        pix_next = pix_reg;
        ch_next  = ch_reg;
        if (accept)
        begin
            if (last_ch)
            begin
                ch_next  = '0;
                pix_next = last_px ? '0 : p + psu_pkg::PIX_W'(1);
            end
            else
            begin
                ch_next  = c + psu_pkg::CH_W'(1);
                pix_next = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
            ch_reg  <= '0;
        end
        else
        begin
            pix_reg <= pix_next;
            ch_reg  <= ch_next;
        end
    end

endmodule

### design/psu_queue.sv
// Short queue of classified words between the front end and the back end.
// Depends on psu_pkg for the word type and depth.
module psu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psu_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output psu_pkg::item_t head
);

    psu_pkg::item_t              mem_reg [psu_pkg::QUEUE_DEPTH];
    logic [psu_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psu_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psu_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == psu_pkg::QCNT_W'(psu_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + psu_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + psu_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + psu_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - psu_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> !pop)
        else $error("Word taken from an empty queue.");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Word written into a full queue.");
`endif

endmodule

### design/psu_back.sv
// Back end of the unfilter: reads the previous row, undoes the prediction, keeps the
// left and upper-left bytes and expands each byte with its filler bytes into the output
// register. Depends on psu_pkg and psu_ram.
module psu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  psu_pkg::item_t q_item,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           is_fill,
    output logic           last_of_run,
    output logic           row_end,
    output logic           clr_busy
);

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] sa, sb, sc, dpa, dpb, dpc;
        logic [9:0]         pa, pb, pc;
        logic [7:0]         res;
        sa  = signed'({3'b000, a});
        sb  = signed'({3'b000, b});
        sc  = signed'({3'b000, c});
        dpa = sb - sc;
        dpb = sa - sc;
        dpc = sa + sb - (sc <<< 1);
        pa  = dpa[10] ? 10'(-dpa) : dpa[9:0];
        pb  = dpb[10] ? 10'(-dpb) : dpb[9:0];
        pc  = dpc[10] ? 10'(-dpc) : dpc[9:0];
        priority if (pa <= pb && pa <= pc)
            res = a;
        else if (pb <= pc)
            res = b;
        else
            res = c;
        return res;
    endfunction

    logic                        clr_busy_reg, clr_busy_next;
    logic [psu_pkg::IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic                        s2_valid_reg, s2_valid_next;
    psu_pkg::item_t              s2_item_reg;
    logic                        s2_fwd_reg, s2_fwd_next;
    logic [7:0]                  s2_fwd_data_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        is_fill_reg, is_fill_next;
    logic                        last_reg, last_next;
    logic                        row_end_reg, row_end_next;
    logic                        row_last_reg, row_last_next;
    logic [psu_pkg::CH_W-1:0]    rem_reg, rem_next;

    logic [7:0]                  left_reg [psu_pkg::MAX_CHANNELS];
    logic [7:0]                  ul_reg [psu_pkg::MAX_CHANNELS];

    logic                        pop_ok, out_free, s2_fire, s2_load;
    logic [psu_pkg::CH_W-1:0]    ch;
    logic [7:0]                  ram_rdata, up_b, left_a, up_left, pred_val, dec;
    logic [8:0]                  sum_ab;
    logic                        ram_we;
    logic [psu_pkg::IDX_W-1:0]   ram_waddr;
    logic [7:0]                  ram_wdata;

    assign pop_ok   = pop && out_valid_reg;
    assign out_free = !out_valid_reg || (pop_ok && rem_reg == '0);
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_load  = q_valid && !clr_busy_reg && (!s2_valid_reg || s2_fire);
    assign q_pop    = s2_load;

    assign ram_we    = clr_busy_reg || s2_fire;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : s2_item_reg.idx;
    assign ram_wdata = clr_busy_reg ? 8'h00 : dec;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (psu_pkg::MAX_ROW_BYTES)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s2_load),
        .raddr (q_item.idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ch      = s2_item_reg.idx[psu_pkg::CH_W-1:0];
        up_b    = s2_fwd_reg ? s2_fwd_data_reg : ram_rdata;
        left_a  = s2_item_reg.first_px ? 8'h00 : left_reg[ch];
        up_left = s2_item_reg.first_px ? 8'h00 : ul_reg[ch];
        sum_ab  = {1'b0, left_a} + {1'b0, up_b};
        unique case (s2_item_reg.pred)
            psu_pkg::PRED_NONE:  pred_val = 8'h00;
            psu_pkg::PRED_SUB:   pred_val = left_a;
            psu_pkg::PRED_UP:    pred_val = up_b;
            psu_pkg::PRED_AVG:   pred_val = sum_ab[8:1];
            psu_pkg::PRED_PAETH: pred_val = paeth(left_a, up_b, up_left);
            psu_pkg::PRED_AVG0:  pred_val = {1'b0, left_a[7:1]};
            default:             pred_val = 8'h00;
        endcase
        dec = s2_item_reg.data + pred_val;
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_fwd_next   = s2_fwd_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
            s2_fwd_next   = s2_fire && (s2_item_reg.idx == q_item.idx);
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end

        clr_cnt_next  = clr_busy_reg ? clr_cnt_reg + psu_pkg::IDX_W'(1) : clr_cnt_reg;
        clr_busy_next = clr_busy_reg &&
                        (clr_cnt_reg != psu_pkg::IDX_W'(psu_pkg::MAX_ROW_BYTES - 1));
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_fill_next   = is_fill_reg;
        last_next      = last_reg;
        row_end_next   = row_end_reg;
        row_last_next  = row_last_reg;
        rem_next       = rem_reg;
        if (s2_fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = dec;
            is_fill_next   = 1'b0;
            rem_next       = s2_item_reg.fill_cnt;
            last_next      = (s2_item_reg.fill_cnt == '0);
            row_last_next  = s2_item_reg.row_last;
            row_end_next   = s2_item_reg.row_last && (s2_item_reg.fill_cnt == '0);
        end
        else if (pop_ok && rem_reg != '0)
        begin
            out_byte_next = psu_pkg::FILL_BYTE;
            is_fill_next  = 1'b1;
            rem_next      = rem_reg - psu_pkg::CH_W'(1);
            last_next     = (rem_reg == psu_pkg::CH_W'(1));
            row_end_next  = row_last_reg && (rem_reg == psu_pkg::CH_W'(1));
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_item_reg     <= q_item;
            s2_fwd_data_reg <= dec;
        end
        out_byte_reg <= out_byte_next;
        is_fill_reg  <= is_fill_next;
        last_reg     <= last_next;
        row_end_reg  <= row_end_next;
        row_last_reg <= row_last_next;
        rem_reg      <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            s2_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < psu_pkg::MAX_CHANNELS; i++)
            begin
                left_reg[i] <= 8'h00;
                ul_reg[i]   <= 8'h00;
            end
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            s2_valid_reg  <= s2_valid_next;
            s2_fwd_reg    <= s2_fwd_next;
            out_valid_reg <= out_valid_next;
            if (s2_fire)
            begin
                left_reg[ch] <= dec;
                ul_reg[ch]   <= up_b;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_fill     = is_fill_reg;
    assign last_of_run = last_reg;
    assign row_end     = row_end_reg;
    assign clr_busy    = clr_busy_reg;

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s2_valid_reg && !out_valid_reg)
        else $error("A word is in flight during the clearing pass.");
    a_fill_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && rem_reg != '0 |=> out_valid_reg && is_fill_reg)
        else $error("A filler byte was lost after a pop.");
    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && row_end_reg |-> last_reg && (rem_reg == '0))
        else $error("Row end flagged on a byte that is not the last of its run.");
`endif

endmodule

### design/png_scanline_unfilter.sv
// PNG scanline unfilter: takes one filtered byte per cycle while full is low and delivers
// the decoded byte, followed by 0xFF filler bytes after the last source channel of each
// pixel. After reset the previous-row memory is cleared, during which full stays high.
// Afterwards one byte is accepted every cycle unless the queue is full; a byte with k
// filler bytes yields 1 + k output words from the output register, so the sustained input
// rate is one byte for every 1 + k output words taken. A pushed byte passes through the
// queue, the previous-row memory read and the output register. Depends on psu_pkg,
// psu_front, psu_queue and psu_back.
module png_scanline_unfilter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  filter_type,
    input  logic [7:0]  data_byte,
    input  logic        new_image,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_fill,
    output logic        last_of_run,
    output logic        row_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [psu_pkg::ROW_W-1:0]    row_pixels_reg, row_pixels_next;
    logic [psu_pkg::CNT_CH_W-1:0] src_ch_reg, src_ch_next;
    logic [psu_pkg::CNT_CH_W-1:0] dst_ch_reg, dst_ch_next;
    logic                         cfg_wr, accept, q_full, q_valid, q_pop, clr_busy;
    psu_pkg::item_t               front_item, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        row_pixels_next = row_pixels_reg;
        src_ch_next     = src_ch_reg;
        dst_ch_next     = dst_ch_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                psu_pkg::REG_ROW_PIXELS:  row_pixels_next = pwdata[psu_pkg::ROW_W-1:0];
                psu_pkg::REG_SRC_CHANNEL: src_ch_next = pwdata[psu_pkg::CNT_CH_W-1:0];
                psu_pkg::REG_DST_CHANNEL: dst_ch_next = pwdata[psu_pkg::CNT_CH_W-1:0];
                default:                  row_pixels_next = row_pixels_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            psu_pkg::REG_ROW_PIXELS:  prdata = 32'(row_pixels_reg);
            psu_pkg::REG_SRC_CHANNEL: prdata = 32'(src_ch_reg);
            psu_pkg::REG_DST_CHANNEL: prdata = 32'(dst_ch_reg);
            default:                  prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pixels_reg <= psu_pkg::ROW_W'(1);
            src_ch_reg     <= psu_pkg::CNT_CH_W'(1);
            dst_ch_reg     <= psu_pkg::CNT_CH_W'(1);
        end
        else
        begin
            row_pixels_reg <= row_pixels_next;
            src_ch_reg     <= src_ch_next;
            dst_ch_reg     <= dst_ch_next;
        end
    end

    assign full   = q_full || clr_busy;
    assign accept = push && !full;

    psu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .filter_type  (filter_type),
        .data_byte    (data_byte),
        .new_image    (new_image),
        .row_pixels   (row_pixels_reg),
        .src_channels (src_ch_reg),
        .dst_channels (dst_ch_reg),
        .item         (front_item)
    );

    psu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    psu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .is_fill     (is_fill),
        .last_of_run (last_of_run),
        .row_end     (row_end),
        .clr_busy    (clr_busy)
    );

endmodule

### tb/psu_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the PNG scanline unfilter: follows the register writes and the accepted
// input bytes, rebuilds each decoded byte with its filler bytes and checks every output word.
// Depends on psu_pkg only.
module psu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  filter_type,
    input  logic [7:0]  data_byte,
    input  logic        new_image,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        is_fill,
    input  logic        last_of_run,
    input  logic        row_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          waiting
);

    typedef struct packed {
        logic [7:0] value;
        logic       fill;
        logic       last;
        logic       row_last;
    } out_word_t;

    out_word_t   decoded_q[$];
    out_word_t   exp_word;
    logic [7:0]  prev_row [psu_pkg::MAX_ROW_BYTES];
    logic [7:0]  left_px [psu_pkg::MAX_CHANNELS];
    logic [7:0]  upleft_px [psu_pkg::MAX_CHANNELS];
    logic [11:0] px_pos;
    logic [2:0]  ch_pos;
    logic [12:0] row_pixels;
    logic [3:0]  src_channels;
    logic [3:0]  dst_channels;
    int          mismatches = 0;

    function automatic int channel_count(input logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (int'(raw) > psu_pkg::MAX_CHANNELS)
            return psu_pkg::MAX_CHANNELS;
        return int'(raw);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int pa;
        int pb;
        int pc;
        pa = int'(b) - int'(c);
        pb = int'(a) - int'(c);
        pc = int'(a) + int'(b) - 2 * int'(c);
        if (pa < 0)
            pa = -pa;
        if (pb < 0)
            pb = -pb;
        if (pc < 0)
            pc = -pc;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic unfilter_byte(input logic [2:0] ft, input logic [7:0] x,
                                 input logic restart);
        int          sc;
        int          dc;
        int          rows;
        int          n;
        logic [11:0] p;
        logic [2:0]  c;
        logic [14:0] idx;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  ul;
        logic [7:0]  d;
        logic [8:0]  sum;
        logic        last_ch;
        logic        last_px;
        out_word_t   w;
        sc = channel_count(src_channels);
        dc = channel_count(dst_channels);
        if (dc < sc)
            dc = sc;
        if (row_pixels == 13'd0)
            rows = 1;
        else if (int'(row_pixels) > psu_pkg::ROW_LIMIT)
            rows = psu_pkg::ROW_LIMIT;
        else
            rows = int'(row_pixels);
        if (restart)
        begin
            px_pos = '0;
            ch_pos = '0;
        end
        p   = px_pos;
        c   = ch_pos;
        idx = {p, c};
        a   = (p == 12'd0) ? 8'd0 : left_px[c];
        ul  = (p == 12'd0) ? 8'd0 : upleft_px[c];
        b   = prev_row[idx];
        case (ft)
            psu_pkg::FT_SUB, psu_pkg::FT_SUB_ALT: d = x + a;
            psu_pkg::FT_UP:                       d = x + b;
            psu_pkg::FT_AVG:
            begin
                sum = {1'b0, a} + {1'b0, b};
                d   = x + sum[8:1];
            end
            psu_pkg::FT_PAETH:                    d = x + paeth_pick(a, b, ul);
            psu_pkg::FT_AVG_ZERO:                 d = x + (a >> 1);
            default:                              d = x;
        endcase
        left_px[c]    = d;
        upleft_px[c]  = b;
        prev_row[idx] = d;
        last_ch = (int'(c) + 1 >= sc);
        last_px = (int'(p) + 1 >= rows);
        n = last_ch ? 1 + dc - sc : 1;
        for (int k = 0; k < n; k++)
        begin
            w.value    = (k == 0) ? d : psu_pkg::FILL_BYTE;
            w.fill     = (k != 0);
            w.last     = (k == n - 1);
            w.row_last = w.last && last_ch && last_px;
            decoded_q.push_back(w);
        end
        if (last_ch)
        begin
            ch_pos = '0;
            px_pos = last_px ? 12'd0 : p + 12'd1;
        end
        else
        begin
            ch_pos = c + 3'd1;
            px_pos = p;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psu_pkg::MAX_ROW_BYTES; i++)
                prev_row[i] = 8'd0;
            for (int i = 0; i < psu_pkg::MAX_CHANNELS; i++)
            begin
                left_px[i]   = 8'd0;
                upleft_px[i] = 8'd0;
            end
            px_pos       = '0;
            ch_pos       = '0;
            row_pixels   = 13'd1;
            src_channels = 4'd1;
            dst_channels = 4'd1;
            decoded_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("out_byte: no word expected, got %02h", out_byte);
                    mismatches++;
                end
                else
                begin
                    exp_word = decoded_q.pop_front();
                    if (out_byte !== exp_word.value)
                    begin
                        $error("out_byte: expected %02h, got %02h", exp_word.value, out_byte);
                        mismatches++;
                    end
                    if (is_fill !== exp_word.fill)
                    begin
                        $error("is_fill: expected %0d, got %0d", exp_word.fill, is_fill);
                        mismatches++;
                    end
                    if (last_of_run !== exp_word.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", exp_word.last,
                               last_of_run);
                        mismatches++;
                    end
                    if (row_end !== exp_word.row_last)
                    begin
                        $error("row_end: expected %0d, got %0d", exp_word.row_last, row_end);
                        mismatches++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    psu_pkg::REG_ROW_PIXELS:  row_pixels   = pwdata[12:0];
                    psu_pkg::REG_SRC_CHANNEL: src_channels = pwdata[3:0];
                    psu_pkg::REG_DST_CHANNEL: dst_channels = pwdata[3:0];
                    default: ;
                endcase
            end
            if (push && !full)
                unfilter_byte(filter_type, data_byte, new_image);
        end
        errors  <= mismatches;
        waiting <= decoded_q.size();
    end

endmodule

### tb/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// Top of the PNG scanline unfilter testbench: clock, reset, register set-up and byte stimulus
// with random idling on the input and output sides, and the final verdict. Depends on psu_pkg,
// png_scanline_unfilter and psu_checker.
module tb_png_scanline_unfilter;

    localparam logic [2:0] FT_UNUSED     = 3'd7;
    localparam int         RANDOM_ITEMS  = 235;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  filter_type = 3'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        new_image = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        is_fill;
    logic        last_of_run;
    logic        row_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          waiting;
    int          idle_pct = 31;
    int          cycles = 0;

    png_scanline_unfilter u_dut (.*);

    psu_checker u_checker (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop    <= ($urandom_range(0, 99) >= idle_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("png_scanline_unfilter: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [2:0] ft, input logic [7:0] value, input logic restart);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        filter_type <= ft;
        data_byte   <= value;
        new_image   <= restart;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic set_geometry(input int rp, input int sc, input int dc);
        reg_write(psu_pkg::REG_ROW_PIXELS, ($urandom() & 32'hFFFF_E000) | rp);
        reg_write(psu_pkg::REG_SRC_CHANNEL, ($urandom() & 32'hFFFF_FFF0) | sc);
        reg_write(psu_pkg::REG_DST_CHANNEL, ($urandom() & 32'hFFFF_FFF0) | dc);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int         sent;
        int         phase;
        int         count;
        int         rp;
        int         sc;
        int         dc;
        int         row_bytes;
        int         row_pos;
        logic [2:0] row_ft;
        logic [2:0] ft;
        logic       restart;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_geometry(2, 3, 5);
        send_byte(psu_pkg::FT_NONE, 8'h00, 1'b1);
        send_byte(psu_pkg::FT_NONE, 8'hFF, 1'b0);
        send_byte(psu_pkg::FT_SUB, 8'h80, 1'b0);
        send_byte(psu_pkg::FT_SUB, 8'h7F, 1'b0);
        send_byte(psu_pkg::FT_SUB_ALT, 8'h01, 1'b0);
        send_byte(psu_pkg::FT_AVG_ZERO, 8'hFE, 1'b0);
        send_byte(psu_pkg::FT_UP, 8'h10, 1'b0);
        send_byte(psu_pkg::FT_AVG, 8'h20, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'hFF, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h33, 1'b0);
        send_byte(psu_pkg::FT_AVG, 8'hC4, 1'b0);
        send_byte(FT_UNUSED, 8'h5A, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h00, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h81, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'hFF, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h40, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'hC0, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h0F, 1'b0);
        settle();

        set_geometry(0, 0, 15);
        send_byte(psu_pkg::FT_UP, 8'hFF, 1'b0);
        send_byte(psu_pkg::FT_SUB, 8'h01, 1'b1);
        send_byte(psu_pkg::FT_PAETH, 8'h80, 1'b0);
        settle();

        set_geometry(8191, 15, 2);
        send_byte(psu_pkg::FT_AVG, 8'hAA, 1'b0);
        send_byte(psu_pkg::FT_PAETH, 8'h55, 1'b0);
        send_byte(psu_pkg::FT_SUB, 8'hFF, 1'b0);
        send_byte(psu_pkg::FT_AVG_ZERO, 8'h00, 1'b0);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                rp = $urandom_range(1, 6);
                sc = $urandom_range(1, 4);
                dc = $urandom_range(1, 8);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       rp = 0;
                    1:       rp = 4096;
                    2:       rp = 8191;
                    default: rp = $urandom_range(0, 8191);
                endcase
                sc = $urandom_range(0, 15);
                dc = $urandom_range(0, 15);
            end
            set_geometry(rp, sc, dc);
            if (rp == 0)
                rp = 1;
            else if (rp > psu_pkg::ROW_LIMIT)
                rp = psu_pkg::ROW_LIMIT;
            if (sc == 0)
                sc = 1;
            else if (sc > psu_pkg::MAX_CHANNELS)
                sc = psu_pkg::MAX_CHANNELS;
            row_bytes = rp * sc;
            row_pos   = 0;
            row_ft    = psu_pkg::FT_NONE;
            idle_pct  = (phase == 3) ? 0 : 31;
            count     = (phase == 3) ? 60 : $urandom_range(15, 35);
            for (int i = 0; i < count; i++)
            begin
                if (i == 0)
                    restart = (phase != 0) && ($urandom_range(0, 1) == 1);
                else
                    restart = ($urandom_range(0, 39) == 0);
                if (restart)
                    row_pos = 0;
                if (row_pos == 0)
                    row_ft = 3'($urandom_range(0, 6));
                ft = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : row_ft;
                send_byte(ft, 8'($urandom_range(0, 255)), restart);
                row_pos = (row_pos + 1 == row_bytes) ? 0 : row_pos + 1;
            end
            sent  += count;
            phase++;
            settle();
        end

        if (errors == 0)
            $display("png_scanline_unfilter: match");
        else
            $display("png_scanline_unfilter: mismatch");
        $finish;
    end

endmodule
